// File: hw/rtl/gts_pkg.sv
// Shared types, token kind codes and keyword helpers for the grammar token scanner.
// Has no dependencies; grammar_token_scanner_unit imports it.

package gts_pkg;

    typedef enum logic [2:0] {
        KIND_NTERM  = 3'd0,
        KIND_TERM   = 3'd1,
        KIND_DOLLAR = 3'd2,
        KIND_LAMBDA = 3'd3,
        KIND_BAR    = 3'd4,
        KIND_ARROW  = 3'd5,
        KIND_NL     = 3'd6,
        KIND_END    = 3'd7
    } kind_t;

    localparam int unsigned LINE_W = 20;
    localparam int unsigned COL_W  = 16;
    localparam int unsigned HASH_W = 64;
    localparam int unsigned TLEN_W = 7;

    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [COL_W-1:0]  COL_MAX  = '1;

    // The hash register holds the running hash already multiplied by 13,
    // so the seed 1337 is stored as 1337 * 13.
    localparam logic [HASH_W-1:0] HASH13_SEED = 64'd17381;

    // Keyword match bits: arrow, bar, dollar, lambda from bit 0 up.
    localparam int unsigned KW_ARROW  = 0;
    localparam int unsigned KW_BAR    = 1;
    localparam int unsigned KW_DOLLAR = 2;
    localparam int unsigned KW_LAMBDA = 3;

    typedef struct packed {
        logic              last;
        logic [COL_W-1:0]  column_number;
        logic [LINE_W-1:0] line_number;
        logic [HASH_W-1:0] token_hash;
        logic              full_res;
        logic [TLEN_W-1:0] token_length;
        kind_t             kind;
    } res_t;

    // Which keywords still agree with byte c at position pos (pos saturates at 7).
    function automatic logic [3:0] kw_hit(input logic [2:0] pos, input logic [7:0] c);
        logic [3:0] hit;
        logic [7:0] lam_ch;
        hit = 4'b0000;
        case (pos)
            3'd0: lam_ch = "l";
            3'd1: lam_ch = "a";
            3'd2: lam_ch = "m";
            3'd3: lam_ch = "b";
            3'd4: lam_ch = "d";
            3'd5: lam_ch = "a";
            default: lam_ch = 8'h00;
        endcase
        hit[KW_ARROW]  = ((pos == 3'd0) && (c == "-")) || ((pos == 3'd1) && (c == ">"));
        hit[KW_BAR]    = (pos == 3'd0) && (c == "|");
        hit[KW_DOLLAR] = (pos == 3'd0) && (c == "$");
        hit[KW_LAMBDA] = (pos < 3'd6) && (c == lam_ch);
        return hit;
    endfunction

    // Kind of a finished token from its flags; any capital letter wins.
    function automatic kind_t classify(input logic upper, input logic [3:0] km,
                                       input logic is1, input logic is2,
                                       input logic is6);
        kind_t k;
        if (upper) begin
            k = KIND_NTERM;
        end else if (km[KW_ARROW] && is2) begin
            k = KIND_ARROW;
        end else if (km[KW_BAR] && is1) begin
            k = KIND_BAR;
        end else if (km[KW_DOLLAR] && is1) begin
            k = KIND_DOLLAR;
        end else if (km[KW_LAMBDA] && is6) begin
            k = KIND_LAMBDA;
        end else begin
            k = KIND_TERM;
        end
        return k;
    endfunction

    function automatic logic [HASH_W-1:0] times13(input logic [HASH_W-1:0] h);
        return (h << 3) + (h << 2) + h;
    endfunction

endpackage

// File: hw/rtl/grammar_token_scanner_unit.sv
// Grammar token scanner top level: tokenizer state, classification and result queue.
// Depends on gts_pkg for kind codes, the result struct and keyword helpers.

// The scanner takes one input word per accepted handshake on the s_ channel:
// a byte in s_tdata, or an end-of-input mark when s_tuser is high. Space, tab
// and CR close a token; newline and end of input close a token and then give
// a token of their own. Each result word on the m_ channel carries kind,
// length, full flag, hash, line and column; m_tlast marks the final result
// caused by one input word.
// All work for an input word is done in the cycle it is accepted, and its
// results are written into a four-entry result queue, whose head drives
// m_tdata directly. The scanner accepts one word every cycle while the queue
// has room for two results; words that cause two results (token plus newline
// or end) fill the queue faster than it drains, so the rate is set by the
// output port at one result per cycle while m_tready stays high.
// Reset (aresetn low, synchronous) clears the queue, closes any open token,
// sets the line to 1 and the column to 0. When the receiver stalls, results
// wait in the queue and s_tready falls once fewer than two entries are free.
// A token that grows to MAX_TOKEN-1 bytes is sent at once with full_res set.

module grammar_token_scanner_unit
    import gts_pkg::*;
#(
    parameter int unsigned MAX_TOKEN = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // ch
    input  logic         s_tuser,   // at_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // kind, token_length, full_res, token_hash,
                                    // line_number, column_number, one zero pad bit
    output logic         m_tlast    // last
);

    localparam int unsigned LEN_W = $clog2(MAX_TOKEN);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN - 1);
    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = 2;
    localparam int unsigned CNT_W = 3;

    // Tokenizer state.
    logic              in_token_reg, in_token_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              upper_reg, upper_next;
    logic [3:0]        km_reg, km_next;
    logic [HASH_W-1:0] hash13_reg, hash13_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;

    // Result queue.
    res_t              fifo_mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              accept, pop;
    logic [1:0]        n_push;
    res_t              res_a, res_b, tok_res, full_res_w, spec_res;
    logic [LEN_W-1:0]  len_inc;
    logic [LEN_W+6:0]  len_ext, len_inc_ext;
    logic [2:0]        pos;
    logic [3:0]        km_char;
    logic              upper_char;
    logic [HASH_W-1:0] hash13_char;
    logic [COL_W-1:0]  col_inc;
    logic [LINE_W-1:0] line_inc;
    logic              is_sep, is_nl;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= CNT_W'(DEPTH - 2));

    assign col_inc  = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    assign is_sep   = (s_tdata == 8'h20) || (s_tdata == 8'h09) || (s_tdata == 8'h0D);
    assign is_nl    = (s_tdata == 8'h0A);

    // Values of the token after this byte joins it.
    assign pos         = (len_reg < LEN_W'(6)) ? len_reg[2:0] : 3'd7;
    assign km_char     = km_reg & kw_hit(pos, s_tdata);
    assign upper_char  = upper_reg || ((s_tdata >= "A") && (s_tdata <= "Z"));
    assign len_inc     = len_reg + 1'b1;
    assign len_ext     = {7'd0, len_reg};
    assign len_inc_ext = {7'd0, len_inc};
    // 13 * (h + c) written as 13 * h + 13 * c, both products as shifts and adds.
    assign hash13_char = times13(hash13_reg) + times13(HASH_W'(s_tdata));

    // The open token as it stands before this word.
    always_comb begin
        tok_res.kind          = classify(upper_reg, km_reg, len_reg == LEN_W'(1),
                                         len_reg == LEN_W'(2), len_reg == LEN_W'(6));
        tok_res.token_length  = len_ext[6:0];
        tok_res.full_res      = 1'b0;
        tok_res.token_hash    = hash13_reg;
        tok_res.line_number   = line_reg;
        tok_res.column_number = col_reg;
        tok_res.last          = is_sep && !s_tuser;
    end

    // The token closed by reaching the length limit with this byte. Its hash
    // register already holds the closing multiply by 13.
    always_comb begin
        full_res_w.kind          = classify(upper_char, km_char, len_inc == LEN_W'(1),
                                            len_inc == LEN_W'(2), len_inc == LEN_W'(6));
        full_res_w.token_length  = len_inc_ext[6:0];
        full_res_w.full_res      = 1'b1;
        full_res_w.token_hash    = hash13_char;
        full_res_w.line_number   = line_reg;
        full_res_w.column_number = col_inc;
        full_res_w.last          = 1'b1;
    end

    // Newline or end result.
    always_comb begin
        spec_res.kind          = s_tuser ? KIND_END : KIND_NL;
        spec_res.token_length  = '0;
        spec_res.full_res      = 1'b0;
        spec_res.token_hash    = '0;
        spec_res.line_number   = s_tuser ? line_reg : line_inc;
        spec_res.column_number = s_tuser ? col_inc : '0;
        spec_res.last          = 1'b1;
    end

    // Next tokenizer state and the results of the accepted word.
    always_comb begin
        in_token_next = in_token_reg;
        len_next      = len_reg;
        upper_next    = upper_reg;
        km_next       = km_reg;
        hash13_next   = hash13_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        n_push        = 2'd0;
        res_a         = tok_res;
        res_b         = spec_res;
        if (accept) begin
            if (s_tuser || is_nl) begin
                if (in_token_reg) begin
                    n_push = 2'd2;
                end else begin
                    n_push = 2'd1;
                    res_a  = spec_res;
                end
                in_token_next = 1'b0;
                len_next      = '0;
                upper_next    = 1'b0;
                km_next       = 4'hF;
                hash13_next   = HASH13_SEED;
                if (s_tuser) begin
                    col_next = col_inc;
                end else begin
                    line_next = line_inc;
                    col_next  = '0;
                end
            end else if (is_sep) begin
                n_push        = in_token_reg ? 2'd1 : 2'd0;
                in_token_next = 1'b0;
                len_next      = '0;
                upper_next    = 1'b0;
                km_next       = 4'hF;
                hash13_next   = HASH13_SEED;
                col_next      = col_inc;
            end else begin
                col_next = col_inc;
                if (len_inc == LEN_LIMIT) begin
                    n_push        = 2'd1;
                    res_a         = full_res_w;
                    in_token_next = 1'b0;
                    len_next      = '0;
                    upper_next    = 1'b0;
                    km_next       = 4'hF;
                    hash13_next   = HASH13_SEED;
                end else begin
                    in_token_next = 1'b1;
                    len_next      = len_inc;
                    upper_next    = upper_char;
                    km_next       = km_char;
                    hash13_next   = hash13_char;
                end
            end
        end
    end

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg <= 1'b0;
            len_reg      <= '0;
            upper_reg    <= 1'b0;
            km_reg       <= 4'hF;
            hash13_reg   <= HASH13_SEED;
            line_reg     <= LINE_W'(1);
            col_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            in_token_reg <= in_token_next;
            len_reg      <= len_next;
            upper_reg    <= upper_next;
            km_reg       <= km_next;
            hash13_reg   <= hash13_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Queue storage needs no reset; entries are only read after being written.
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            fifo_mem_reg[wr_ptr_reg] <= res_a;
        end
        if (n_push == 2'd2) begin
            fifo_mem_reg[wr_ptr_reg + 1'b1] <= res_b;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {1'b0, fifo_mem_reg[rd_ptr_reg][110:0]};
    assign m_tlast  = fifo_mem_reg[rd_ptr_reg].last;

`ifndef SYNTH
    // The queue never holds more entries than it has.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    // A closed token leaves no length or hash behind.
    a_idle_token: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_token_reg |-> (len_reg == '0) && (hash13_reg == HASH13_SEED))
        else $error("token state not cleared");

    // An open token has at least one byte and stays below the length limit.
    a_open_token: assert property (@(posedge aclk) disable iff (!aresetn)
        in_token_reg |-> (len_reg != '0) && (len_reg < LEN_LIMIT))
        else $error("open token length out of range");

    // The line counter starts at one and only saturates, so it is never zero.
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");
`endif

endmodule

// File: verif/grammar_token_scanner_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for grammar_token_scanner_unit: streams bytes and end marks in,
// predicts every token word in-line and checks each m_ word field by field.
// Depends on gts_pkg (kind codes, result struct, widths) and the scanner RTL.

module grammar_token_scanner_unit_tb;
    import gts_pkg::*;

    localparam int unsigned TOK_MAX      = 128;
    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned RANDOM_WORDS = 1600;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned MAX_REPORTS  = 40;
    localparam int unsigned DRAIN_CYCLES = 20;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    typedef struct packed {
        logic       at_end;
        logic [7:0] ch;
    } scan_in_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         m_tlast;

    // Words waiting to be driven, and token words the scanner still owes us.
    scan_in_t bytes_to_send[$];
    res_t     tokens_due[$];

    // Shadow copy of the scanner state.
    logic              tok_open  = 1'b0;
    int unsigned       tok_len   = 0;
    logic              tok_upper = 1'b0;
    logic [3:0]        kw_live   = 4'hF;
    logic [63:0]       tok_hash  = 64'd1337;
    logic [LINE_W-1:0] line_cnt  = LINE_W'(1);
    logic [COL_W-1:0]  col_cnt   = '0;

    // Keyword spellings, one per match bit from bit 0 up.
    string kw_word [4] = '{"->", "|", "$", "lambda"};
    kind_t kw_kind [4] = '{KIND_ARROW, KIND_BAR, KIND_DOLLAR, KIND_LAMBDA};
    string near_kw [12] = '{"-", ">", "->>", "-->", "lambd", "lambdaa", "Lambda",
                            "||", "$$", "|$", "l", "a"};

    int unsigned err_count   = 0;
    int unsigned idle_cycles = 0;
    int unsigned words_out   = 0;
    int unsigned sent        = 0;
    int unsigned tx_gap      = 0;
    int unsigned tx_burst    = 0;
    int unsigned rx_gap      = 0;
    int unsigned rx_burst    = 0;
    int unsigned hold_left   = 0;
    int unsigned holds_done  = 0;
    scan_in_t    nxt;

    grammar_token_scanner_unit #(
        .MAX_TOKEN(TOK_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------

    function automatic void queue_token(kind_t k, int unsigned len, logic full,
                                        logic [63:0] h, logic last);
        res_t r;
        r.kind          = k;
        r.token_length  = len[TLEN_W-1:0];
        r.full_res      = full;
        r.token_hash    = h;
        r.line_number   = line_cnt;
        r.column_number = col_cnt;
        r.last          = last;
        tokens_due.push_back(r);
    endfunction

    // Classify the open token, queue it, and start afresh.
    function automatic void close_token(logic full, logic last);
        kind_t k;
        logic  hit;
        int    i;
        k   = KIND_TERM;
        hit = 1'b0;
        if (tok_upper) begin
            k = KIND_NTERM;
        end else begin
            for (i = 0; i < 4; i++) begin
                if (!hit && kw_live[i] && tok_len == kw_word[i].len()) begin
                    k   = kw_kind[i];
                    hit = 1'b1;
                end
            end
        end
        // The closing zero byte of the token folds in as one more multiply.
        queue_token(k, tok_len, full, tok_hash * 64'd13, last);
        tok_open  = 1'b0;
        tok_len   = 0;
        tok_upper = 1'b0;
        kw_live   = 4'hF;
        tok_hash  = 64'd1337;
    endfunction

    function automatic void bump_col();
        if (col_cnt != COL_MAX) begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    // Work out the token words that one accepted input word causes.
    function automatic void scan_word(scan_in_t w);
        int i;
        if (w.at_end) begin
            if (tok_open) begin
                close_token(1'b0, 1'b0);
            end
            bump_col();
            queue_token(KIND_END, 0, 1'b0, 64'd0, 1'b1);
        end else if (w.ch == CH_SPACE || w.ch == CH_TAB || w.ch == CH_CR) begin
            // A separator closes the token with the column as it stood before it.
            if (tok_open) begin
                close_token(1'b0, 1'b1);
            end
            bump_col();
        end else if (w.ch == CH_LF) begin
            if (tok_open) begin
                close_token(1'b0, 1'b0);
            end
            if (line_cnt != LINE_MAX) begin
                line_cnt = line_cnt + 1'b1;
            end
            col_cnt = '0;
            queue_token(KIND_NL, 0, 1'b0, 64'd0, 1'b1);
        end else begin
            bump_col();
            tok_open = 1'b1;
            if (w.ch >= CH_UP_A && w.ch <= CH_UP_Z) begin
                tok_upper = 1'b1;
            end
            for (i = 0; i < 4; i++) begin
                if (tok_len >= kw_word[i].len() || kw_word[i][tok_len] != w.ch) begin
                    kw_live[i] = 1'b0;
                end
            end
            tok_hash = tok_hash * 64'd13 + {56'd0, w.ch};
            tok_len  = tok_len + 1;
            // A token that hits the length limit goes out at once, flagged full.
            if (tok_len >= TOK_MAX - 1) begin
                close_token(1'b1, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endfunction

    function automatic void check_result();
        res_t want;
        if (tokens_due.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: unexpected word, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
            end
        end else begin
            want = tokens_due.pop_front();
            check_field("kind", want.kind, m_tdata[2:0]);
            check_field("token_length", want.token_length, m_tdata[9:3]);
            check_field("full_res", want.full_res, m_tdata[10]);
            check_field("token_hash", want.token_hash, m_tdata[74:11]);
            check_field("line_number", want.line_number, m_tdata[94:75]);
            check_field("column_number", want.column_number, m_tdata[110:95]);
            check_field("pad", 64'd0, m_tdata[111]);
            check_field("last", want.last, m_tlast);
        end
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: feeds the s_ channel from bytes_to_send and runs the
    // prediction on every word the scanner accepts.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tok_open  = 1'b0;
            tok_len   = 0;
            tok_upper = 1'b0;
            kw_live   = 4'hF;
            tok_hash  = 64'd1337;
            line_cnt  = LINE_W'(1);
            col_cnt   = '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                scan_word({s_tuser, s_tdata});
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
                nxt = bytes_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tuser  <= nxt.at_end;
                if (tx_burst > 0) begin
                    tx_gap = 0;
                    tx_burst--;
                end else begin
                    tx_gap = pick_gap();
                    if ($urandom_range(0, 39) == 0) begin
                        tx_burst = $urandom_range(20, 150);
                    end
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver: checks every accepted m_ word and
    // stalls the scanner at random. Twice it holds off for a long
    // stretch so that the result queue fills and s_tready drops.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
                words_out++;
                if (rx_burst > 0) begin
                    rx_gap = 0;
                    rx_burst--;
                end else begin
                    rx_gap = pick_gap();
                    if ($urandom_range(0, 39) == 0) begin
                        rx_burst = $urandom_range(20, 150);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holds_done < 2 && words_out >= 200 * (holds_done + 1)) begin
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // The run ends in failure when neither side has moved a word for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The producer only advances on falling edges, so its
    // pushes never share a time step with the driver's pops.
    // ------------------------------------------------------------------

    task automatic send_word(logic [7:0] c, logic e);
        while (bytes_to_send.size() >= 16) begin
            @(negedge aclk);
        end
        bytes_to_send.push_back({e, c});
        sent++;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_word(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] ident_byte();
        logic [7:0] pun [5];
        int unsigned r;
        pun = '{8'h2D, 8'h5F, 8'h3E, 8'h7C, 8'h24};
        r   = $urandom_range(0, 9);
        if (r < 6) begin
            return 8'h61 + 8'($urandom_range(0, 25));
        end else if (r < 8) begin
            return CH_UP_A + 8'($urandom_range(0, 25));
        end else if (r == 8) begin
            return 8'h30 + 8'($urandom_range(0, 9));
        end
        return pun[$urandom_range(0, 4)];
    endfunction

    // Any byte value that joins a token.
    function automatic logic [7:0] token_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // One token-like chunk with its separator, or a stray noise word.
    task automatic random_chunk();
        logic [7:0] seps [3];
        int unsigned r;
        int unsigned n;
        int unsigned i;
        seps = '{CH_SPACE, CH_TAB, CH_CR};
        r    = $urandom_range(0, 99);
        if (r < 10) begin
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
        end else begin
            if (r < 35) begin
                send_text(kw_word[$urandom_range(0, 3)]);
            end else if (r < 50) begin
                send_text(near_kw[$urandom_range(0, 11)]);
            end else if (r < 72) begin
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++) send_word(ident_byte(), 1'b0);
            end else if (r < 92) begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) send_word(token_byte(), 1'b0);
            end else if (r < 97) begin
                // Long tokens straddle the length limit; a rare one crosses it twice.
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 260)
                                                 : $urandom_range(120, 135);
                for (i = 0; i < n; i++) send_word(ident_byte(), 1'b0);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) send_word(seps[$urandom_range(0, 2)], 1'b0);
            end else if (r < 92) begin
                send_word(CH_LF, 1'b0);
            end else if (r < 97) begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every keyword, a nonterminal, a terminal made of the byte
        // extremes with a zero byte in it, each separator, a newline, an end
        // mark with no token open and with one open, and input after an end.
        send_text("-> | $ lambda");
        send_word(CH_TAB, 1'b0);
        send_text("Z");
        send_word(CH_CR, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
        send_text("x");
        send_word(8'($urandom_range(0, 255)), 1'b1);

        // Random grammar-like text with some noise.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            random_chunk();
        end

        sent = 0;
        while (sent < 40) begin
            random_chunk();
        end

        while (bytes_to_send.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        while (tokens_due.size() != 0) begin
            @(negedge aclk);
        end
        // Give any stray word a chance to show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/gts_pkg.sv
hw/rtl/grammar_token_scanner_unit.sv
verif/grammar_token_scanner_unit_tb.sv
